// ----- rtl/sorted_keyed_record_list_macros.svh -----
// assertion macros for the sorted keyed record list
`ifndef SORTED_KEYED_RECORD_LIST_MACROS_SVH
`define SORTED_KEYED_RECORD_LIST_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SKRL_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SKRL_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SKRL_ASSERT(label, clk, rst_n, prop, msg)
`define SKRL_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ----- rtl/skrl_pkg.sv -----
// ----------------------------------------------------------------------------
// skrl_pkg
// shared types and constants of the sorted keyed record list
// ----------------------------------------------------------------------------
package skrl_pkg;
  localparam int KeyW          = 31;
  localparam int NameW         = 240;
  localparam int DefCapacity   = 64;
  localparam int DefNameBytes  = 30;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_FIND   = 2'd2,
    MODE_DUMP   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_DUP   = 3'd1,
    ST_NONE  = 3'd2,
    ST_FULL  = 3'd3,
    ST_EMPTY = 3'd4
  } status_t;

  // one command word passed from front to back
  typedef struct packed {
    mode_t            mode;
    logic [KeyW-1:0]  key;
    logic [NameW-1:0] name;
  } cmd_t;
endpackage

// ----- rtl/skrl_front.sv -----
// ----------------------------------------------------------------------------
// skrl_front
// accepts command words, masks the name and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module skrl_front #(
  parameter int NAME_BYTES = skrl_pkg::DefNameBytes
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  skrl_pkg::cmd_t       cmd_in,
  output logic                 full,
  output logic                 q_valid,
  output skrl_pkg::cmd_t       q_head,
  input  logic                 pop
);
  localparam int KeepBits = 8 * NAME_BYTES;

  skrl_pkg::cmd_t       slot_r [2];
  logic           [1:0] cnt_r, cnt_nxt;
  logic                 rd_r, rd_nxt, wr_r, wr_nxt;
  skrl_pkg::cmd_t       masked;
  logic [skrl_pkg::NameW-1:0] keep_mask;

  always_comb begin
    keep_mask = '0;
    keep_mask[KeepBits-1:0] = '1;
    masked = cmd_in;
    masked.name = cmd_in.name & keep_mask;
  end

  assign full    = cnt_r[1];
  assign q_valid = (cnt_r != 2'd0);
  assign q_head  = slot_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
    rd_nxt  = rd_r ^ pop;
    wr_nxt  = wr_r ^ push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
    end
    if (push) slot_r[wr_r] <= masked;
  end
endmodule

// ----- rtl/skrl_back.sv -----
// ----------------------------------------------------------------------------
// skrl_back
// sorted record array of compare and shift cells plus the result sequencer
// ----------------------------------------------------------------------------
`include "sorted_keyed_record_list_macros.svh"
module skrl_back #(
  parameter int CAPACITY = skrl_pkg::DefCapacity
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  skrl_pkg::cmd_t                q_head,
  output logic                          pop,
  output logic                          idle,
  output logic                          out_strobe,
  output logic [2:0]                    out_status,
  output logic [skrl_pkg::KeyW-1:0]     out_key,
  output logic [skrl_pkg::NameW-1:0]    out_name,
  output logic                          out_last
);
  localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CntW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DUMP} state_t;

  logic [skrl_pkg::KeyW-1:0]  key_r  [CAPACITY];
  logic [skrl_pkg::NameW-1:0] name_r [CAPACITY];
  logic [CntW-1:0]            count_r, count_nxt;
  logic [CntW-1:0]            dump_r, dump_nxt;
  state_t                     state_r, state_nxt;
  skrl_pkg::cmd_t             cmd_r;

  // registered result word
  logic                       res_strobe_r, strobe_nxt;
  logic [2:0]                 res_status_r, status_nxt;
  logic [skrl_pkg::KeyW-1:0]  res_key_r, key_nxt;
  logic [skrl_pkg::NameW-1:0] res_name_r, name_nxt;
  logic                       res_last_r, last_nxt;

  // per-cell compare vectors
  logic [CAPACITY-1:0] occ, hit, less;
  logic                found;
  logic [IdxW-1:0]     hit_idx;
  logic                is_full;

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      occ[i]  = (CntW'(i) < count_r);
      hit[i]  = occ[i] && (key_r[i] == cmd_r.key);
      less[i] = occ[i] && (key_r[i] < cmd_r.key);
      if (hit[i]) hit_idx = IdxW'(i);
    end
    found   = |hit;
    is_full = (count_r == CntW'(CAPACITY));
  end

  logic do_ins, do_del;
  assign do_ins = (state_r == S_EXEC) && (cmd_r.mode == skrl_pkg::MODE_INSERT) &&
                  !found && !is_full;
  assign do_del = (state_r == S_EXEC) && (cmd_r.mode == skrl_pkg::MODE_DELETE) && found;

  assign pop  = (state_r == S_IDLE) && q_valid;
  assign idle = (state_r == S_IDLE);

  assign out_strobe = res_strobe_r;
  assign out_status = res_status_r;
  assign out_key    = res_key_r;
  assign out_name   = res_name_r;
  assign out_last   = res_last_r;

  // cell array: each cell shifts up, down, loads or holds
  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (do_ins && !less[i]) begin
        if (i == 0 || less[(i == 0) ? 0 : i-1]) begin
          key_r[i]  <= cmd_r.key;
          name_r[i] <= cmd_r.name;
        end else begin
          key_r[i]  <= key_r[(i == 0) ? 0 : i-1];
          name_r[i] <= name_r[(i == 0) ? 0 : i-1];
        end
      end else if (do_del && (IdxW'(i) >= hit_idx) && (i + 1 < CAPACITY)) begin
        key_r[i]  <= key_r[(i + 1 < CAPACITY) ? i+1 : i];
        name_r[i] <= name_r[(i + 1 < CAPACITY) ? i+1 : i];
      end
    end
  end

  // sequencer next state and next result word
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    dump_nxt   = dump_r;
    strobe_nxt = 1'b0;
    status_nxt = res_status_r;
    key_nxt    = res_key_r;
    name_nxt   = res_name_r;
    last_nxt   = res_last_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        strobe_nxt = 1'b1;
        status_nxt = skrl_pkg::ST_OK;
        key_nxt    = cmd_r.key;
        name_nxt   = '0;
        last_nxt   = 1'b1;
        state_nxt  = S_IDLE;
        unique case (cmd_r.mode)
          skrl_pkg::MODE_INSERT: begin
            if (found)        status_nxt = skrl_pkg::ST_DUP;
            else if (is_full) status_nxt = skrl_pkg::ST_FULL;
            else              count_nxt  = count_r + 1'b1;
          end
          skrl_pkg::MODE_DELETE: begin
            if (found) count_nxt  = count_r - 1'b1;
            else       status_nxt = skrl_pkg::ST_NONE;
          end
          skrl_pkg::MODE_FIND: begin
            if (found) name_nxt   = name_r[hit_idx];
            else       status_nxt = skrl_pkg::ST_NONE;
          end
          skrl_pkg::MODE_DUMP: begin
            if (count_r == '0) begin
              status_nxt = skrl_pkg::ST_EMPTY;
              key_nxt    = '0;
            end else begin
              // setup cycle, records follow one per cycle
              strobe_nxt = 1'b0;
              dump_nxt   = '0;
              state_nxt  = S_DUMP;
            end
          end
          default: ;
        endcase
      end
      S_DUMP: begin
        strobe_nxt = 1'b1;
        status_nxt = skrl_pkg::ST_OK;
        key_nxt    = key_r[dump_r[IdxW-1:0]];
        name_nxt   = name_r[dump_r[IdxW-1:0]];
        last_nxt   = (dump_r + 1'b1 == count_r);
        dump_nxt   = dump_r + 1'b1;
        if (dump_r + 1'b1 == count_r) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      dump_r       <= '0;
      res_strobe_r <= 1'b0;
      res_status_r <= '0;
      res_key_r    <= '0;
      res_name_r   <= '0;
      res_last_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      dump_r       <= dump_nxt;
      res_strobe_r <= strobe_nxt;
      res_status_r <= status_nxt;
      res_key_r    <= key_nxt;
      res_name_r   <= name_nxt;
      res_last_r   <= last_nxt;
      if (pop) cmd_r <= q_head;
    end
  end

  `SKRL_ASSERT(a_count_bound, clk, rst_n, count_r <= CntW'(CAPACITY), "count over capacity")
  `SKRL_ASSERT(a_pop_idle, clk, rst_n, pop |=> (state_r == S_EXEC), "pop without exec")
  `SKRL_ASSERT(a_ins_grow, clk, rst_n, do_ins |=> (count_r == $past(count_r) + 1'b1), "insert count")
  `SKRL_ASSERT(a_del_shrink, clk, rst_n, do_del |=> (count_r == $past(count_r) - 1'b1), "delete count")
endmodule

// ----- rtl/sorted_keyed_record_list.sv -----
// ----------------------------------------------------------------------------
// sorted_keyed_record_list
// sorted record table with insert, delete, find and dump commands
// ----------------------------------------------------------------------------
// a command word is taken when start is high and busy low; it goes into a
// two-entry queue and the back end runs it on a row of compare and shift
// cells. the back end takes a word from the queue when the queue count
// register shows it and the back end is idle; insert, delete and find run
// in the exec state and put their result on the ports from the result
// registers, and the back end takes no new word until it is back in idle.
// a dump first spends a setup step in the exec state, then gives one result
// per stored record, one per cycle, and takes no new word until the last
// record; busy rises only while the queue holds two words.
// results appear for one cycle under out_valid and cannot be held off.
`include "sorted_keyed_record_list_macros.svh"
module sorted_keyed_record_list #(
  parameter int CAPACITY   = skrl_pkg::DefCapacity,
  parameter int NAME_BYTES = skrl_pkg::DefNameBytes
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [30:0] in_record_key,
  input  logic [63:0] in_name_in_0,
  input  logic [63:0] in_name_in_1,
  input  logic [63:0] in_name_in_2,
  input  logic [47:0] in_name_in_3,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [30:0] out_key_out,
  output logic [63:0] out_name_out_0,
  output logic [63:0] out_name_out_1,
  output logic [63:0] out_name_out_2,
  output logic [47:0] out_name_out_3,
  output logic        out_last
);
  skrl_pkg::cmd_t cmd_in, q_head;
  logic q_full, q_valid, pop, push, be_idle;
  logic [skrl_pkg::NameW-1:0] name_o;

  // queue full holds the source off
  assign busy = q_full;
  assign push = start && !q_full;

  always_comb begin
    cmd_in.mode = skrl_pkg::mode_t'(in_mode);
    cmd_in.key  = in_record_key;
    cmd_in.name = {in_name_in_3, in_name_in_2, in_name_in_1, in_name_in_0};
  end

  skrl_front #(.NAME_BYTES(NAME_BYTES)) u_front (
    .clk, .rst_n, .push, .cmd_in, .full(q_full), .q_valid, .q_head, .pop
  );

  skrl_back #(.CAPACITY(CAPACITY)) u_back (
    .clk, .rst_n, .q_valid, .q_head, .pop, .idle(be_idle),
    .out_strobe(out_valid), .out_status, .out_key(out_key_out),
    .out_name(name_o), .out_last
  );

  // word lanes of the stored name
  assign out_name_out_0 = name_o[63:0];
  assign out_name_out_1 = name_o[127:64];
  assign out_name_out_2 = name_o[191:128];
  assign out_name_out_3 = name_o[239:192];

  `SKRL_ASSERT(a_push_room, clk, rst_n, push |-> !q_full, "push into full queue")
  `SKRL_ASSERT(a_pop_valid, clk, rst_n, pop |-> (q_valid && be_idle), "pop from empty queue")
  `SKRL_ASSERT_NR(a_rst_quiet, clk, !rst_n |=> !out_valid, "result during reset")
endmodule
